[rtl/core/sbal_pkg.sv]
`default_nettype none
package sbal_pkg;

  // slab and slot geometry
  localparam int MAX_SLABS        = 16;
  localparam int SLAB_W           = 4;
  localparam int CREATED_W        = 5;
  localparam int OBJECTS_PER_SLAB = 4096;
  localparam int SLOT_W           = 12;
  localparam int CNT_W            = 13;

  // bitmap storage: 64-bit words
  localparam int WORD_W  = 64;
  localparam int BIT_W   = 6;
  localparam int WIDX_W  = SLOT_W - BIT_W;
  localparam int ADDR_W  = SLAB_W + WIDX_W;

  // request and size classes
  localparam int SIZE_W         = 21;
  localparam int CLS_W          = 5;
  localparam int MIN_OBJECT_LOG2 = 5;
  localparam int MAX_CLASS_LOG2 = 20;
  localparam int OFF_W          = 32;
  localparam int STATUS_W       = 2;

  // actions
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SLAB  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FREE_IGN = 2'd3;

endpackage
`default_nettype wire

[rtl/core/sbal_in_if.sv]
`default_nettype none
interface sbal_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [sbal_pkg::SIZE_W-1:0] request_size;
  logic [sbal_pkg::SLAB_W-1:0] free_slab;
  logic [sbal_pkg::SLOT_W-1:0] free_slot;

  modport source (output valid, action, request_size, free_slab, free_slot, input ready);
  modport sink   (input valid, action, request_size, free_slab, free_slot, output ready);
endinterface
`default_nettype wire

[rtl/core/sbal_out_if.sv]
`default_nettype none
interface sbal_out_if;
  logic                          valid;
  logic                          ready;
  logic [sbal_pkg::STATUS_W-1:0] status;
  logic [sbal_pkg::SLAB_W-1:0]   slab_index;
  logic [sbal_pkg::SLOT_W-1:0]   slot_index;
  logic [sbal_pkg::CLS_W-1:0]    object_size_log2;
  logic [sbal_pkg::OFF_W-1:0]    offset_in_slab;

  modport source (output valid, status, slab_index, slot_index, object_size_log2,
                  offset_in_slab, input ready);
  modport sink   (input valid, status, slab_index, slot_index, object_size_log2,
                  offset_in_slab, output ready);
endinterface
`default_nettype wire

[rtl/core/slab_bitmap_allocator_unit.sv]
`default_nettype none
// Slab allocator with power-of-two size classes (minimum 32 bytes) and a
// 64-bit-word bitmap per slab, 16 slabs of 4096 objects. One request is in
// work at a time; in_if.ready is high only when the unit is idle and the
// previous result has been transferred. After reset a clearing pass writes
// all 1024 bitmap words before the first request is taken. A zero size, an
// oversized class or a free of a slab not yet created is answered at accept.
// Any other free goes through accept, one bitmap read and one check/write.
// An allocate is accepted and then examines slab descriptors in turn (up
// to 16); in a fitting slab it reads bitmap words in turn (up to 64 words),
// each through a read step and a check step as the bitmap memory read is
// registered. Each request gives exactly one result.
module slab_bitmap_allocator_unit (
  input  wire        clk,
  input  wire        rst_n,
  sbal_in_if.sink    in_if,
  sbal_out_if.source out_if
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;

  localparam int SW = sbal_pkg::SLAB_W;
  localparam int TW = sbal_pkg::SLOT_W;
  localparam int WW = sbal_pkg::WORD_W;
  localparam int AW = sbal_pkg::ADDR_W;
  localparam int CW = sbal_pkg::CLS_W;
  localparam int NW = sbal_pkg::CNT_W;

  // class of a request size: ceil log2 of max(size, minimum object size)
  function automatic logic [CW-1:0] size_class(input logic [sbal_pkg::SIZE_W-1:0] sz);
    logic [sbal_pkg::SIZE_W-1:0] m;
    logic [CW-1:0]               c;
    m = sz - sbal_pkg::SIZE_W'(1);
    c = CW'(sbal_pkg::MIN_OBJECT_LOG2);
    for (int i = sbal_pkg::MIN_OBJECT_LOG2; i < sbal_pkg::SIZE_W; i++) begin
      if (m[i]) c = CW'(i + 1);
    end
    return c;
  endfunction

  // lowest clear bit of a bitmap word
  function automatic logic [sbal_pkg::BIT_W-1:0] low_zero(input logic [WW-1:0] w);
    logic [sbal_pkg::BIT_W-1:0] b;
    b = '0;
    for (int i = WW - 1; i >= 0; i--) begin
      if (!w[i]) b = sbal_pkg::BIT_W'(i);
    end
    return b;
  endfunction

  logic [2:0]                     state_r, state_nxt;
  logic [AW-1:0]                  clr_r, clr_nxt;
  logic                           act_r, act_nxt;
  logic [CW-1:0]                  cls_r, cls_nxt;
  logic [SW-1:0]                  slab_r, slab_nxt;
  logic [sbal_pkg::WIDX_W-1:0]    word_r, word_nxt;
  logic [sbal_pkg::BIT_W-1:0]     bit_r, bit_nxt;
  logic [sbal_pkg::CREATED_W-1:0] created_r, created_nxt;
  logic [CW-1:0]                  class_r [sbal_pkg::MAX_SLABS];
  logic [NW-1:0]                  count_r [sbal_pkg::MAX_SLABS];

  // bitmap memory
  logic [WW-1:0] mem [2**AW];
  logic [WW-1:0] rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [WW-1:0] mem_wdata;

  // descriptor updates
  logic          cnt_we, cls_we;
  logic [SW-1:0] desc_idx;
  logic [NW-1:0] cnt_wdata;

  // result register
  logic                          out_valid_r;
  logic [sbal_pkg::STATUS_W-1:0] out_status_r;
  logic [SW-1:0]                 out_slab_r;
  logic [TW-1:0]                 out_slot_r;
  logic [CW-1:0]                 out_cls_r;
  logic [sbal_pkg::OFF_W-1:0]    out_off_r;
  logic                          ld;
  logic [sbal_pkg::STATUS_W-1:0] ld_status;
  logic [SW-1:0]                 ld_slab;
  logic [TW-1:0]                 ld_slot;
  logic [CW-1:0]                 ld_cls;

  logic          accept;
  logic [CW-1:0] req_cls;
  logic          hit, last;
  logic [SW-1:0] new_slab;
  logic [sbal_pkg::BIT_W-1:0] zb;

  assign in_if.ready = (state_r == S_IDLE) && !out_valid_r;
  assign accept      = in_if.valid && in_if.ready;
  assign req_cls     = size_class(in_if.request_size);
  assign new_slab    = created_r[SW-1:0];
  assign zb          = low_zero(rdata_r);

  // descriptor compare for the slab under scan
  assign hit  = ({1'b0, slab_r} < created_r) && (class_r[slab_r] == cls_r) &&
                (count_r[slab_r] < NW'(sbal_pkg::OBJECTS_PER_SLAB));
  assign last = ((sbal_pkg::CREATED_W'(slab_r) + 1'b1) >= created_r) ||
                (slab_r == SW'(sbal_pkg::MAX_SLABS - 1));

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    act_nxt     = act_r;
    cls_nxt     = cls_r;
    slab_nxt    = slab_r;
    word_nxt    = word_r;
    bit_nxt     = bit_r;
    created_nxt = created_r;
    mem_we      = 1'b0;
    mem_waddr   = {slab_r, word_r};
    mem_wdata   = rdata_r;
    mem_raddr   = {slab_r, word_r};
    cnt_we      = 1'b0;
    cls_we      = 1'b0;
    desc_idx    = slab_r;
    cnt_wdata   = count_r[slab_r];
    ld          = 1'b0;
    ld_status   = sbal_pkg::ST_OK;
    ld_slab     = '0;
    ld_slot     = '0;
    ld_cls      = '0;
    case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (&clr_r) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          act_nxt = in_if.action;
          if (in_if.action == sbal_pkg::ACT_FREE) begin
            if ({1'b0, in_if.free_slab} >= created_r) begin
              ld        = 1'b1;
              ld_status = sbal_pkg::ST_FREE_IGN;
            end else begin
              slab_nxt  = in_if.free_slab;
              word_nxt  = in_if.free_slot[TW-1:sbal_pkg::BIT_W];
              bit_nxt   = in_if.free_slot[sbal_pkg::BIT_W-1:0];
              state_nxt = S_RD;
            end
          end else if (in_if.request_size == '0) begin
            ld        = 1'b1;
            ld_status = sbal_pkg::ST_ZERO;
          end else if (req_cls > CW'(sbal_pkg::MAX_CLASS_LOG2)) begin
            ld        = 1'b1;
            ld_status = sbal_pkg::ST_NO_SLAB;
          end else begin
            cls_nxt   = req_cls;
            slab_nxt  = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          word_nxt  = '0;
          state_nxt = S_RD;
        end else if (last) begin
          state_nxt = S_IDLE;
          ld        = 1'b1;
          if (created_r < sbal_pkg::CREATED_W'(sbal_pkg::MAX_SLABS)) begin
            // open a new slab and take its slot 0
            mem_we      = 1'b1;
            mem_waddr   = {new_slab, {sbal_pkg::WIDX_W{1'b0}}};
            mem_wdata   = WW'(1);
            desc_idx    = new_slab;
            cls_we      = 1'b1;
            cnt_we      = 1'b1;
            cnt_wdata   = NW'(1);
            created_nxt = created_r + 1'b1;
            ld_slab     = new_slab;
            ld_cls      = cls_r;
          end else begin
            ld_status = sbal_pkg::ST_NO_SLAB;
          end
        end else begin
          slab_nxt = slab_r + 1'b1;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (act_r == sbal_pkg::ACT_FREE) begin
          state_nxt = S_IDLE;
          ld        = 1'b1;
          if (rdata_r[bit_r]) begin
            mem_we             = 1'b1;
            mem_wdata[bit_r]   = 1'b0;
            cnt_we             = 1'b1;
            cnt_wdata          = (count_r[slab_r] != '0) ? count_r[slab_r] - 1'b1
                                                         : count_r[slab_r];
          end else begin
            ld_status = sbal_pkg::ST_FREE_IGN;
          end
        end else if (!(&rdata_r)) begin
          state_nxt       = S_IDLE;
          mem_we          = 1'b1;
          mem_wdata[zb]   = 1'b1;
          cnt_we          = 1'b1;
          cnt_wdata       = count_r[slab_r] + 1'b1;
          ld              = 1'b1;
          ld_slab         = slab_r;
          ld_slot         = {word_r, zb};
          ld_cls          = cls_r;
        end else begin
          word_nxt  = word_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      created_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      created_r <= created_nxt;
      if (ld) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  // working payload registers
  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    cls_r  <= cls_nxt;
    slab_r <= slab_nxt;
    word_r <= word_nxt;
    bit_r  <= bit_nxt;
  end

  // slab descriptors
  always_ff @(posedge clk) begin
    if (cnt_we) count_r[desc_idx] <= cnt_wdata;
    if (cls_we) class_r[desc_idx] <= cls_r;
  end

  // bitmap memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[mem_raddr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (ld) begin
      out_status_r <= ld_status;
      out_slab_r   <= ld_slab;
      out_slot_r   <= ld_slot;
      out_cls_r    <= ld_cls;
      out_off_r    <= sbal_pkg::OFF_W'(ld_slot) << ld_cls;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.status           = out_status_r;
  assign out_if.slab_index       = out_slab_r;
  assign out_if.slot_index       = out_slot_r;
  assign out_if.object_size_log2 = out_cls_r;
  assign out_if.offset_in_slab   = out_off_r;

endmodule
`default_nettype wire

[verif/tb_slab_bitmap_allocator_unit.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_slab_bitmap_allocator_unit;

  localparam int WDOG_LIMIT  = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 283;

  typedef struct packed {
    logic                          action;
    logic [sbal_pkg::SIZE_W-1:0]   request_size;
    logic [sbal_pkg::SLAB_W-1:0]   free_slab;
    logic [sbal_pkg::SLOT_W-1:0]   free_slot;
  } req_t;

  typedef struct packed {
    logic [sbal_pkg::STATUS_W-1:0] status;
    logic [sbal_pkg::SLAB_W-1:0]   slab_index;
    logic [sbal_pkg::SLOT_W-1:0]   slot_index;
    logic [sbal_pkg::CLS_W-1:0]    object_size_log2;
    logic [sbal_pkg::OFF_W-1:0]    offset_in_slab;
  } grant_t;

  typedef struct packed {
    req_t   req;
    logic   typed;
    grant_t grant;
  } row_t;

  typedef struct packed {
    logic [sbal_pkg::SLAB_W-1:0] slab;
    logic [sbal_pkg::SLOT_W-1:0] slot;
  } handle_t;

  logic clk;
  logic rst_n;

  sbal_in_if  in_if ();
  sbal_out_if out_if ();

  slab_bitmap_allocator_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // allocator shadow state
  logic                       slab_live [sbal_pkg::MAX_SLABS];
  logic [sbal_pkg::CLS_W-1:0] slab_cls  [sbal_pkg::MAX_SLABS];
  logic [sbal_pkg::CNT_W-1:0] slab_cnt  [sbal_pkg::MAX_SLABS];
  logic                       slot_map  [sbal_pkg::MAX_SLABS*sbal_pkg::OBJECTS_PER_SLAB];
  int                         slabs_made;

  grant_t  pending_grants[$];
  handle_t live_handles[$];
  row_t    directed_rows[$];

  int fails = 0;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  bit hold_taken = 1'b0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // work out the grant for one request and advance the shadow state
  function automatic grant_t allocate_or_free(req_t r);
    grant_t g;
    logic [sbal_pkg::SIZE_W:0] sz;
    int cls;
    int s;
    int t;
    g = '0;
    if (r.action == sbal_pkg::ACT_FREE) begin
      if (int'(r.free_slab) >= slabs_made || !slab_live[r.free_slab] ||
          !slot_map[{r.free_slab, r.free_slot}]) begin
        g.status = sbal_pkg::ST_FREE_IGN;
      end else begin
        slot_map[{r.free_slab, r.free_slot}] = 1'b0;
        if (slab_cnt[r.free_slab] > 0) slab_cnt[r.free_slab]--;
        g.status = sbal_pkg::ST_OK;
      end
      return g;
    end
    if (r.request_size == 0) begin
      g.status = sbal_pkg::ST_ZERO;
      return g;
    end
    sz  = (r.request_size < 32) ? 32 : r.request_size;
    cls = 0;
    while (((sbal_pkg::SIZE_W+1)'(1) << cls) < sz) cls++;
    if (cls > sbal_pkg::MAX_CLASS_LOG2) begin
      g.status = sbal_pkg::ST_NO_SLAB;
      return g;
    end
    // first fitting slab in creation order, lowest clear slot
    for (s = 0; s < slabs_made; s++) begin
      if (!slab_live[s] || slab_cls[s] != cls ||
          slab_cnt[s] >= sbal_pkg::OBJECTS_PER_SLAB) continue;
      for (t = 0; t < sbal_pkg::OBJECTS_PER_SLAB; t++) begin
        if (!slot_map[s*sbal_pkg::OBJECTS_PER_SLAB + t]) begin
          slot_map[s*sbal_pkg::OBJECTS_PER_SLAB + t] = 1'b1;
          slab_cnt[s]++;
          g.status           = sbal_pkg::ST_OK;
          g.slab_index       = sbal_pkg::SLAB_W'(s);
          g.slot_index       = sbal_pkg::SLOT_W'(t);
          g.object_size_log2 = sbal_pkg::CLS_W'(cls);
          g.offset_in_slab   = sbal_pkg::OFF_W'(t) << cls;
          return g;
        end
      end
    end
    if (slabs_made >= sbal_pkg::MAX_SLABS) begin
      g.status = sbal_pkg::ST_NO_SLAB;
      return g;
    end
    s = slabs_made;
    slabs_made++;
    slab_live[s] = 1'b1;
    slab_cls[s]  = sbal_pkg::CLS_W'(cls);
    slab_cnt[s]  = 1;
    slot_map[s*sbal_pkg::OBJECTS_PER_SLAB] = 1'b1;
    g.status           = sbal_pkg::ST_OK;
    g.slab_index       = sbal_pkg::SLAB_W'(s);
    g.object_size_log2 = sbal_pkg::CLS_W'(cls);
    return g;
  endfunction

  // offer one request, hold it until transfer, then log the expected grant
  task automatic send_req(req_t r, logic typed, grant_t typed_grant);
    grant_t g;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.action       <= r.action;
    in_if.request_size <= r.request_size;
    in_if.free_slab    <= r.free_slab;
    in_if.free_slot    <= r.free_slot;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    g = allocate_or_free(r);
    if (typed) g = typed_grant;
    pending_grants.push_back(g);
    if (g.status == sbal_pkg::ST_OK && r.action == sbal_pkg::ACT_ALLOC)
      live_handles.push_back({g.slab_index, g.slot_index});
  endtask

  function automatic req_t alloc_req(int sz);
    req_t r;
    r = '0;
    r.action       = sbal_pkg::ACT_ALLOC;
    r.request_size = sbal_pkg::SIZE_W'(sz);
    return r;
  endfunction

  function automatic req_t free_req(int slab, int slot);
    req_t r;
    r = '0;
    r.action    = sbal_pkg::ACT_FREE;
    r.free_slab = sbal_pkg::SLAB_W'(slab);
    r.free_slot = sbal_pkg::SLOT_W'(slot);
    return r;
  endfunction

  function automatic grant_t mk_grant(logic [sbal_pkg::STATUS_W-1:0] st, int slab, int slot,
                                      int cls);
    grant_t g;
    g.status           = st;
    g.slab_index       = sbal_pkg::SLAB_W'(slab);
    g.slot_index       = sbal_pkg::SLOT_W'(slot);
    g.object_size_log2 = sbal_pkg::CLS_W'(cls);
    g.offset_in_slab   = sbal_pkg::OFF_W'(slot) << cls;
    return g;
  endfunction

  // random request: mostly allocations across classes, frees mostly of live objects
  function automatic req_t random_req();
    req_t r;
    int k;
    int idx;
    handle_t h;
    if ($urandom_range(99) < 40) begin
      if (live_handles.size() > 0 && $urandom_range(99) < 80) begin
        idx = $urandom_range(live_handles.size() - 1);
        h   = live_handles[idx];
        live_handles.delete(idx);
        r = free_req(h.slab, h.slot);
      end else begin
        r = free_req($urandom_range(15), $urandom_range(4095));
      end
      r.request_size = sbal_pkg::SIZE_W'($urandom);
      return r;
    end
    k = $urandom_range(22);
    if (k == 22)      r = alloc_req($urandom_range((1 << sbal_pkg::SIZE_W) - 1));
    else if (k == 21) r = alloc_req($urandom_range((1 << sbal_pkg::SIZE_W) - 1, (1 << 20) + 1));
    else if (k == 0)  r = alloc_req($urandom_range(1));
    else              r = alloc_req($urandom_range(1 << k, (1 << (k-1)) + 1));
    r.free_slab = sbal_pkg::SLAB_W'($urandom);
    r.free_slot = sbal_pkg::SLOT_W'($urandom);
    return r;
  endfunction

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_cnt   = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_grants.size() == 0) begin
        $error("result transfer with no grant expected");
        fails++;
      end else begin
        want = pending_grants.pop_front();
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          fails++;
        end
        if (out_if.slab_index !== want.slab_index) begin
          $error("slab_index: expected %0d, got %0d", want.slab_index, out_if.slab_index);
          fails++;
        end
        if (out_if.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, out_if.slot_index);
          fails++;
        end
        if (out_if.object_size_log2 !== want.object_size_log2) begin
          $error("object_size_log2: expected %0d, got %0d", want.object_size_log2,
                 out_if.object_size_log2);
          fails++;
        end
        if (out_if.offset_in_slab !== want.offset_in_slab) begin
          $error("offset_in_slab: expected %0h, got %0h", want.offset_in_slab,
                 out_if.offset_in_slab);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // stimulus
  initial begin
    int i;
    int phase;
    row_t row;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    slabs_made     = 0;
    for (i = 0; i < sbal_pkg::MAX_SLABS; i++) begin
      slab_live[i] = 1'b0;
      slab_cls[i]  = '0;
      slab_cnt[i]  = '0;
    end
    for (i = 0; i < sbal_pkg::MAX_SLABS*sbal_pkg::OBJECTS_PER_SLAB; i++) slot_map[i] = 1'b0;

    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.action       <= sbal_pkg::ACT_ALLOC;
    in_if.request_size <= '0;
    in_if.free_slab    <= '0;
    in_if.free_slot    <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table: typed rows for readable cases, the rest predicted
    directed_rows.push_back({alloc_req(0),       1'b1, mk_grant(sbal_pkg::ST_ZERO, 0, 0, 0)});
    directed_rows.push_back({alloc_req(1),       1'b1, mk_grant(sbal_pkg::ST_OK, 0, 0, 5)});
    directed_rows.push_back({alloc_req(32),      1'b1, mk_grant(sbal_pkg::ST_OK, 0, 1, 5)});
    directed_rows.push_back({alloc_req(33),      1'b1, mk_grant(sbal_pkg::ST_OK, 1, 0, 6)});
    directed_rows.push_back({alloc_req(1 << 20), 1'b1, mk_grant(sbal_pkg::ST_OK, 2, 0, 20)});
    directed_rows.push_back({alloc_req((1 << 20) + 1), 1'b1,
                             mk_grant(sbal_pkg::ST_NO_SLAB, 0, 0, 0)});
    directed_rows.push_back({alloc_req((1 << sbal_pkg::SIZE_W) - 1), 1'b1,
                             mk_grant(sbal_pkg::ST_NO_SLAB, 0, 0, 0)});
    directed_rows.push_back({free_req(0, 1),     1'b1, mk_grant(sbal_pkg::ST_OK, 0, 0, 0)});
    directed_rows.push_back({free_req(0, 1),     1'b1,
                             mk_grant(sbal_pkg::ST_FREE_IGN, 0, 0, 0)});
    directed_rows.push_back({free_req(15, 4095), 1'b1,
                             mk_grant(sbal_pkg::ST_FREE_IGN, 0, 0, 0)});
    directed_rows.push_back({alloc_req(20),      1'b1, mk_grant(sbal_pkg::ST_OK, 0, 1, 5)});
    directed_rows.push_back({alloc_req(1 << 20), 1'b1, mk_grant(sbal_pkg::ST_OK, 2, 1, 20)});
    directed_rows.push_back({free_req(3, 0),     1'b1,
                             mk_grant(sbal_pkg::ST_FREE_IGN, 0, 0, 0)});
    directed_rows.push_back({free_req(2, 0),     1'b1, mk_grant(sbal_pkg::ST_OK, 0, 0, 0)});
    directed_rows.push_back({free_req(1, 4095),  1'b1,
                             mk_grant(sbal_pkg::ST_FREE_IGN, 0, 0, 0)});
    directed_rows.push_back({alloc_req(64),      1'b1, mk_grant(sbal_pkg::ST_OK, 1, 1, 6)});
    // one slab for each remaining class
    for (i = 7; i < sbal_pkg::MAX_CLASS_LOG2; i++)
      directed_rows.push_back({alloc_req((1 << i) - 3), 1'b0, grant_t'('0)});
    foreach (directed_rows[j]) begin
      row = directed_rows[j];
      send_req(row.req, row.typed, row.grant);
    end

    // random part over the idling phases, with one long receiver hold-off
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        3: begin send_idle_pct = 33; recv_stall_pct = 33; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_req = 1'b1; end
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) send_req(random_req(), 1'b0, grant_t'('0));
    end

    // a few closing requests on the smallest class
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_req(alloc_req(32), 1'b0, grant_t'('0));
    send_req(free_req(0, 4095), 1'b0, grant_t'('0));
    send_req(alloc_req(17), 1'b0, grant_t'('0));
    in_if.valid <= 1'b0;

    // drain
    while (pending_grants.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fails == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
